[rtl/brle_pkg.sv]
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants of the binary run length encoder: result word
// layout, the bundle a step hands to the result queue, and queue sizing.
// ----------------------------------------------------------------------------
package brle_pkg;

   // Field widths
   localparam int CODE_W    = 16;   // width of a code word / rsp_tdata
   localparam int CW_W      = 5;    // width of the code width register
   localparam logic [CW_W-1:0] CW_RESET = 5'd8;

   // One step emits at most this many words
   localparam int STEP_MAX  = 3;
   localparam int STEP_N_W  = $clog2(STEP_MAX + 1);

   // Result queue sizing
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One result word
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              hdr;
      logic              lst;
   } result_type;

   // Words produced by one step, in order from item[0]
   typedef struct packed {
      logic                         valid;
      logic [STEP_N_W-1:0]          count;
      result_type [STEP_MAX-1:0]    item;
   } push_type;

endpackage

[rtl/brle_in_reg.sv]
// ----------------------------------------------------------------------------
// brle_in_reg
// Input register: captures one input word and holds it until the encoder
// step consumes it. Accepts a new word in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
module brle_in_reg (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic req_bit,
   input  logic req_eos,
   input  logic take,
   output logic held_valid,
   output logic held_bit,
   output logic held_eos
);

   logic valid_ff, valid_in;
   logic bit_ff;
   logic eos_ff;

   // Free when empty or when the held word is consumed this cycle
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         bit_ff <= req_bit;
         eos_ff <= req_eos;
      end
   end

   assign held_valid = valid_ff;
   assign held_bit   = bit_ff;
   assign held_eos   = eos_ff;

endmodule

[rtl/brle_step.sv]
// ----------------------------------------------------------------------------
// brle_step
// Encoder step: run state, code width register and the combinational logic
// that turns one held bit into zero to three result words.
// ----------------------------------------------------------------------------
module brle_step #(
   parameter int LIMIT_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [brle_pkg::CW_W-1:0]   csr_wr_data,
   input  logic                        held_valid,
   input  logic                        held_bit,
   input  logic                        held_eos,
   input  logic [brle_pkg::QCNT_W-1:0] space,
   output logic                        take,
   output brle_pkg::push_type          push
);

   localparam logic [brle_pkg::CW_W-1:0] LIMIT =
      brle_pkg::CW_W'((LIMIT_WIDTH < brle_pkg::CODE_W) ? LIMIT_WIDTH : brle_pkg::CODE_W);

   logic [brle_pkg::CW_W-1:0]   code_width_ff, code_width_in;
   logic                        started_ff, started_in;
   logic                        cur_bit_ff, cur_bit_in;
   logic [brle_pkg::CODE_W-1:0] count_ff, count_in;

   logic [brle_pkg::CW_W-1:0]   width;
   logic [brle_pkg::CODE_W-1:0] max_code;
   logic [brle_pkg::CODE_W-1:0] sat_count;
   logic [brle_pkg::CODE_W-1:0] run_next;
   logic                        run_bit;
   logic                        run_started;
   logic [brle_pkg::STEP_N_W-1:0] n_run;
   brle_pkg::result_type [brle_pkg::STEP_MAX-1:0] words;
   brle_pkg::result_type        flush_word;

   // Clamp the code width and form the largest code
   always_comb begin
      width = (code_width_ff == '0) ? brle_pkg::CW_W'(1) : code_width_ff;
      if (width > LIMIT) begin
         width = LIMIT;
      end
      max_code = {brle_pkg::CODE_W{1'b1}} >> (brle_pkg::CW_W'(brle_pkg::CODE_W) - width);
   end

   // Run update: header, bit change, overflow or plain extend
   always_comb begin
      words       = '0;
      n_run       = '0;
      run_bit     = cur_bit_ff;
      run_started = started_ff;
      run_next    = count_ff;
      priority if (!started_ff) begin
         words[0].code = {{(brle_pkg::CODE_W-1){1'b0}}, held_bit};
         words[0].hdr  = 1'b1;
         n_run         = brle_pkg::STEP_N_W'(1);
         run_started   = 1'b1;
         run_bit       = held_bit;
         run_next      = brle_pkg::CODE_W'(1);
      end else if (held_bit != cur_bit_ff) begin
         words[0].code = (count_ff > max_code) ? max_code : count_ff;
         n_run         = brle_pkg::STEP_N_W'(1);
         run_bit       = held_bit;
         run_next      = brle_pkg::CODE_W'(1);
      end else if (count_ff >= max_code) begin
         words[0].code = max_code;
         n_run         = brle_pkg::STEP_N_W'(2);
         run_next      = brle_pkg::CODE_W'(1);
      end else begin
         run_next      = count_ff + brle_pkg::CODE_W'(1);
      end
   end

   // Append the flush word on end of stream, then consume the held word
   // once the queue has room for all its results
   always_comb begin
      sat_count       = (run_next > max_code) ? max_code : run_next;
      flush_word.code = sat_count;
      flush_word.hdr  = 1'b0;
      flush_word.lst  = 1'b1;
      push.item       = words;
      push.count      = n_run;
      if (held_eos) begin
         push.count = n_run + brle_pkg::STEP_N_W'(1);
         unique case (n_run)
            2'd0:    push.item[0] = flush_word;
            2'd1:    push.item[1] = flush_word;
            default: push.item[2] = flush_word;
         endcase
      end
      take       = held_valid && (brle_pkg::QCNT_W'(push.count) <= space);
      push.valid = take && (push.count != '0);
   end

   // Next run state
   always_comb begin
      started_in = started_ff;
      cur_bit_in = cur_bit_ff;
      count_in   = count_ff;
      if (take) begin
         if (held_eos) begin
            started_in = 1'b0;
            cur_bit_in = 1'b0;
            count_in   = '0;
         end else begin
            started_in = run_started;
            cur_bit_in = run_bit;
            count_in   = run_next;
         end
      end
      code_width_in = csr_wr_en ? csr_wr_data : code_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_width_ff <= brle_pkg::CW_RESET;
         started_ff    <= 1'b0;
         cur_bit_ff    <= 1'b0;
         count_ff      <= '0;
      end else begin
         code_width_ff <= code_width_in;
         started_ff    <= started_in;
         cur_bit_ff    <= cur_bit_in;
         count_ff      <= count_in;
      end
   end

endmodule

[rtl/brle_out_queue.sv]
// ----------------------------------------------------------------------------
// brle_out_queue
// Result queue: takes up to three words from one step at once and drains
// one word per cycle toward the result channel while it is ready.
// ----------------------------------------------------------------------------
module brle_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  brle_pkg::push_type            push,
   output logic [brle_pkg::QCNT_W-1:0]   space,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output brle_pkg::result_type          rsp_word
);

   brle_pkg::result_type [brle_pkg::QUEUE_DEPTH-1:0] entries_ff;
   logic [brle_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [brle_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [brle_pkg::QCNT_W-1:0] cnt_ff, cnt_in;
   logic [brle_pkg::QCNT_W-1:0] push_n;
   logic                        pop;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_word   = entries_ff[rd_ptr_ff];
   assign pop        = rsp_tvalid && rsp_tready;
   assign space      = brle_pkg::QCNT_W'(brle_pkg::QUEUE_DEPTH) - cnt_ff;
   assign push_n     = push.valid ? brle_pkg::QCNT_W'(push.count) : '0;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + brle_pkg::QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + brle_pkg::QPTR_W'(pop);
      cnt_in    = cnt_ff + push_n - brle_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Write the step's words at consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < brle_pkg::STEP_MAX; i++) begin
         if (push.valid && (brle_pkg::STEP_N_W'(i) < push.count)) begin
            entries_ff[brle_pkg::QPTR_W'(wr_ptr_ff + brle_pkg::QPTR_W'(i))] <= push.item[i];
         end
      end
   end

   // Fill count never passes the depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= brle_pkg::QCNT_W'(brle_pkg::QUEUE_DEPTH))
      else $error("result queue count past depth");

   // A step only pushes what fits
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push_n <= space))
      else $error("result queue overrun");

   // A lone pop drops the count by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.valid) |=> (cnt_ff == $past(cnt_ff) - brle_pkg::QCNT_W'(1)))
      else $error("result queue count slip on pop");

endmodule

[rtl/binary_run_length_encoder.sv]
// ----------------------------------------------------------------------------
// binary_run_length_encoder
// Encodes a bit stream as a header bit followed by fixed width run lengths.
// ----------------------------------------------------------------------------
// The block takes one bit per cycle on the req_ channel while the result
// queue has room, and returns its code words on the rsp_ channel, one word
// per cycle while rsp_tready is high. A bit is held in an input register,
// then the encoder step moves its results (zero to three words) into a
// four-word result queue, whose fill count drives rsp_tvalid. A bit that
// causes at most one word sustains one item per cycle while rsp_tready is
// high; an item whose words do not fit the free queue slots waits in the
// input register until they do, so overflow and end of stream items can
// hold the input once the queue is full. The code width register takes
// effect on the next item; write it only while no words are pending. A
// change in the middle of a stream applies to the run being counted.
// ----------------------------------------------------------------------------
module binary_run_length_encoder #(
   parameter int MAX_CODE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // code_width
   // Input bits
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [0] bit_value, [7:1] zero
   input  logic        req_tlast,     // end_of_stream
   // Result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [15:0] code_value
   output logic        rsp_tuser,     // [0] is_header
   output logic        rsp_tlast      // last
);

   logic                        take;
   logic                        held_valid;
   logic                        held_bit;
   logic                        held_eos;
   logic [brle_pkg::QCNT_W-1:0] space;
   brle_pkg::push_type          push;
   brle_pkg::result_type        rsp_word;

   // Hold the incoming bit
   brle_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_bit    (req_tdata[0]),
      .req_eos    (req_tlast),
      .take       (take),
      .held_valid (held_valid),
      .held_bit   (held_bit),
      .held_eos   (held_eos)
   );

   // Update the run and form its words
   brle_step #(
      .LIMIT_WIDTH (MAX_CODE_WIDTH)
   ) u_step (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .held_valid  (held_valid),
      .held_bit    (held_bit),
      .held_eos    (held_eos),
      .space       (space),
      .take        (take),
      .push        (push)
   );

   // Queue the words toward the result channel
   brle_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = rsp_word.code;
   assign rsp_tuser = rsp_word.hdr;
   assign rsp_tlast = rsp_word.lst;

endmodule

[tb/tb_binary_run_length_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_run_length_encoder
// Self-checking bench for the binary run length encoder. A short scripted
// sequence covers the header, one-bit streams, run overflow, flush after
// overflow, clamped and mid-stream code widths. Random streams under random
// code widths follow. Every word is checked against an in-bench encoder or
// the typed words of a script row, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_binary_run_length_encoder;

   localparam int MAX_W         = 16;
   localparam int DRAIN_CYCLES  = 6;     // input register plus step, with margin
   localparam int STALL_LIMIT   = 2000;  // cycles without any word moving
   localparam int RANDOM_PHASES = 8;
   localparam int SIDE_REQ      = 0;
   localparam int SIDE_RSP      = 1;

   typedef brle_pkg::result_type [0:2] typed_words_type;

   typedef enum logic {ROW_BIT, ROW_WIDTH} row_kind_type;

   // One scripted step: a bit to send, or a code width to write.
   // n_typed < 0 takes the words from the encoder model.
   typedef struct packed {
      row_kind_type              kind;
      logic                      bit_v;
      logic                      eos;
      logic [brle_pkg::CW_W-1:0] width;
      int                        n_typed;
      typed_words_type           typed;
   } script_row_type;

   localparam brle_pkg::result_type NO_WORD  = '0;
   localparam typed_words_type      NO_TYPED = '0;
   localparam brle_pkg::result_type HDR0     = {16'd0, 1'b1, 1'b0};
   localparam brle_pkg::result_type HDR1     = {16'd1, 1'b1, 1'b0};
   localparam brle_pkg::result_type RUN0     = {16'd0, 1'b0, 1'b0};
   localparam brle_pkg::result_type RUN1     = {16'd1, 1'b0, 1'b0};
   localparam brle_pkg::result_type LAST1    = {16'd1, 1'b0, 1'b1};

   localparam int SCRIPT_LEN = 23;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // one-bit stream at the reset width: header and flush together
      '{ROW_BIT,   1'b1, 1'b1, 5'd0,  2, '{HDR1, LAST1, NO_WORD}},
      // width 0 acts as 1: every repeat overflows
      '{ROW_WIDTH, 1'b0, 1'b0, 5'd0,  0, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b0, 5'd0,  1, '{HDR0, NO_WORD, NO_WORD}},
      '{ROW_BIT,   1'b0, 1'b0, 5'd0,  2, '{RUN1, RUN0, NO_WORD}},
      '{ROW_BIT,   1'b1, 1'b0, 5'd0,  1, '{RUN1, NO_WORD, NO_WORD}},
      // overflow followed by flush
      '{ROW_BIT,   1'b1, 1'b1, 5'd0,  3, '{RUN1, RUN0, LAST1}},
      // width above the limit acts as the limit
      '{ROW_WIDTH, 1'b0, 1'b0, 5'd31, 0, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b0, 5'd0, -1, NO_TYPED},
      // narrow the width mid-stream: pending run saturates, then overflows
      '{ROW_WIDTH, 1'b0, 1'b0, 5'd2,  0, NO_TYPED},
      '{ROW_BIT,   1'b1, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b1, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b1, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b1, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b1, 5'd0, -1, NO_TYPED},
      // full width, one-bit stream of a zero
      '{ROW_WIDTH, 1'b0, 1'b0, 5'd16, 0, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b1, 5'd0,  2, '{HDR0, LAST1, NO_WORD}},
      '{ROW_BIT,   1'b1, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b1, 1'b0, 5'd0, -1, NO_TYPED},
      '{ROW_BIT,   1'b0, 1'b1, 5'd0, -1, NO_TYPED}
   };

   logic            clock;
   logic            reset       = 1'b1;
   logic            csr_wr_en   = 1'b0;
   logic [4:0]      csr_wr_data = '0;
   logic            req_tvalid  = 1'b0;
   logic            req_tready;
   logic [7:0]      req_tdata   = '0;    // [0] bit_value, [7:1] zero
   logic            req_tlast   = 1'b0;  // end_of_stream
   logic            rsp_tvalid;
   logic            rsp_tready  = 1'b0;
   logic [15:0]     rsp_tdata;           // [15:0] code_value
   logic            rsp_tuser;           // [0] is_header
   logic            rsp_tlast;           // last

   // Encoder state as the bench tracks it
   logic                        run_open       = 1'b0;
   logic                        run_bit        = 1'b0;
   logic [brle_pkg::CODE_W-1:0] run_len        = '0;
   logic [brle_pkg::CW_W-1:0]   code_width_reg = brle_pkg::CW_RESET;

   brle_pkg::result_type step_words [$];   // words of the last encoded bit
   brle_pkg::result_type due_words [$];    // words still owed by the block
   int unsigned     calm_left [2];    // remaining gap-free words per side
   int unsigned     fail_count  = 0;
   int unsigned     stall_cycles = 0;

   binary_run_length_encoder #(.MAX_CODE_WIDTH(MAX_W)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Pick an idle length: mostly none, some short, a few long, and now and
   // then a stretch of back-to-back words.
   function automatic int unsigned idle_len(input int side);
      int unsigned r;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left[side] = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic brle_pkg::result_type make_word(
      input logic [brle_pkg::CODE_W-1:0] code, input logic hdr, input logic lst);
      brle_pkg::result_type w;
      w.code = code;
      w.hdr  = hdr;
      w.lst  = lst;
      return w;
   endfunction

   // Largest code for the current width, after clamping it to 1..MAX_W
   function automatic int unsigned code_max();
      int unsigned w;
      w = code_width_reg;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      if (w > brle_pkg::CODE_W) w = brle_pkg::CODE_W;
      return (1 << w) - 1;
   endfunction

   // Append one word to the words of the current bit
   function automatic void add_word(input brle_pkg::result_type w);
      step_words.insert(step_words.size(), w);
   endfunction

   // Advance the encoder by one bit and collect the words it emits
   function automatic void encode_bit(input logic b, input logic eos);
      int unsigned cap;
      int unsigned held;
      cap = code_max();
      step_words.delete();
      if (!run_open) begin
         add_word(make_word({{(brle_pkg::CODE_W-1){1'b0}}, b}, 1'b1, 1'b0));
         run_open = 1'b1;
         run_bit  = b;
         run_len  = brle_pkg::CODE_W'(1);
      end else if (b != run_bit) begin
         held = (run_len > cap) ? cap : run_len;
         add_word(make_word(held[brle_pkg::CODE_W-1:0], 1'b0, 1'b0));
         run_bit = b;
         run_len = brle_pkg::CODE_W'(1);
      end else if (run_len >= cap) begin
         // overflow: full code, then an empty run of the other bit
         add_word(make_word(cap[brle_pkg::CODE_W-1:0], 1'b0, 1'b0));
         add_word(make_word('0, 1'b0, 1'b0));
         run_len = brle_pkg::CODE_W'(1);
      end else begin
         run_len = run_len + brle_pkg::CODE_W'(1);
      end
      if (eos) begin
         held = (run_len > cap) ? cap : run_len;
         add_word(make_word(held[brle_pkg::CODE_W-1:0], 1'b0, 1'b1));
         run_open = 1'b0;
         run_bit  = 1'b0;
         run_len  = '0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // Send one bit, then queue the words it owes
   task automatic send_bit(input logic b, input logic eos, input int n_typed,
                           input typed_words_type typed);
      int unsigned gap;
      gap = idle_len(SIDE_REQ);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, b};
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      encode_bit(b, eos);
      if (n_typed >= 0) begin
         for (int k = 0; k < n_typed; k++) due_words.insert(due_words.size(), typed[k]);
      end else begin
         foreach (step_words[k]) due_words.insert(due_words.size(), step_words[k]);
      end
   endtask

   // Hold the input idle until every owed word is out and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [brle_pkg::CW_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
      code_width_reg = value;
   endtask

   // Random code width, then random streams that favor runs
   task automatic random_phase();
      int unsigned r;
      int unsigned left;
      int unsigned len;
      logic        b;
      r = $urandom_range(0, 99);
      settle();
      if (r < 55)      write_width(brle_pkg::CW_W'($urandom_range(1, 4)));
      else if (r < 75) write_width(brle_pkg::CW_W'($urandom_range(5, 16)));
      else if (r < 87) write_width('0);
      else             write_width(brle_pkg::CW_W'($urandom_range(17, 31)));
      left = 20;
      while (left > 0) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                           : $urandom_range(1, 16);
         b = 1'($urandom_range(0, 1));
         for (int k = 1; k <= len; k++) begin
            send_bit(b, k == len, -1, NO_TYPED);
            if ($urandom_range(0, 3) == 0) b = ~b;
         end
         left = (left > len) ? left - len : 0;
      end
   endtask

   // Stimulus and verdict
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == ROW_WIDTH) begin
            settle();
            write_width(SCRIPT[i].width);
         end else begin
            send_bit(SCRIPT[i].bit_v, SCRIPT[i].eos, SCRIPT[i].n_typed,
                     SCRIPT[i].typed);
         end
      end

      repeat (RANDOM_PHASES) random_phase();

      settle();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: hold ready for a while, then drop it for a random gap
   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         gap = idle_len(SIDE_RSP);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Compare each word leaving the block with the oldest owed word
   always @(posedge clock) begin
      brle_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word code=%0d hdr=%0b last=%0b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
         end else begin
            want = due_words.pop_front();
            if (rsp_tdata !== want.code)
               report_mismatch($sformatf("code_value %0d, want %0d",
                                         rsp_tdata, want.code));
            if (rsp_tuser !== want.hdr)
               report_mismatch($sformatf("is_header %0b, want %0b",
                                         rsp_tuser, want.hdr));
            if (rsp_tlast !== want.lst)
               report_mismatch($sformatf("last %0b, want %0b",
                                         rsp_tlast, want.lst));
         end
      end
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          csr_wr_en) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: no word moved for %0d cycles, %0d words owed",
                     STALL_LIMIT, due_words.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule
